FILE: hdl/ubfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the UART bootloader flash programmer.
// Used by ubfp_tx and by the top level; no dependencies.
package ubfp_pkg;

    localparam int BLOCK_BYTES = 256;
    localparam int BUF_AW      = $clog2(BLOCK_BYTES);
    localparam int CNT_W       = 9;

    localparam logic [7:0] RSP_ACK      = 8'h79;
    localparam logic [7:0] BYTE_SYNC    = 8'h7F;
    localparam logic [7:0] BYTE_ERASE   = 8'h44;
    localparam logic [7:0] BYTE_ERASE_N = 8'hBB;
    localparam logic [7:0] BYTE_WRITE   = 8'h31;
    localparam logic [7:0] BYTE_WRITE_N = 8'hCE;
    localparam logic [7:0] BYTE_FILL    = 8'hFF;

    localparam logic [31:0] TIMEOUT_RESET = 32'd100000000;
    localparam logic [3:0]  RETRIES_RESET = 4'd3;
    localparam logic [31:0] BASE_RESET    = 32'h0800_0000;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_IMAGE = 2'd1,
        OP_RSP   = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_RETRIES = 2'd1,
        CFG_BASE    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_READY    = 2'd0,
        ST_DONE     = 2'd1,
        ST_FAILED   = 2'd2,
        ST_REJECTED = 2'd3
    } t_status;

    typedef enum logic {
        KIND_TX     = 1'b0,
        KIND_STATUS = 1'b1
    } t_kind;

    // Where the transmitted byte comes from.
    typedef enum logic [1:0] {
        SEL_CONST = 2'd0,
        SEL_MEM   = 2'd1,
        SEL_CHK   = 2'd2
    } t_sel;

    typedef struct packed {
        t_kind       kind;
        t_status     status;
        t_sel        sel;
        logic [7:0]  cbyte;
        logic        first;
    } t_mid;

endpackage

FILE: hdl/ubfp_tx.sv
`timescale 1ns / 1ps
// Block buffer memory, byte assembly with running checksum, and output register.
// Depends on ubfp_pkg.
module ubfp_tx
    import ubfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_mid              i_mid,
    input  logic              i_we,
    input  logic [BUF_AW-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [BUF_AW-1:0] i_raddr,
    output logic              o_can_load,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [7:0]        o_tx_byte,
    output logic [1:0]        o_status
);

    logic [7:0] r_mem [BLOCK_BYTES];
    logic [7:0] r_rdata;
    logic       r_mv;
    t_mid       r_mid;
    logic       r_ov;
    logic [7:0] r_chk;
    logic       r_kind;
    logic [7:0] r_byte;
    logic [1:0] r_status;
    logic       adv;
    logic [7:0] b;

    assign adv        = !r_ov || i_ready;
    assign o_can_load = !r_mv || adv;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_comb begin
        case (r_mid.sel)
            SEL_MEM: b = r_rdata;
            SEL_CHK: b = r_chk;
            default: b = r_mid.cbyte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (i_load) begin
                r_mv <= 1'b1;
            end else if (adv) begin
                r_mv <= 1'b0;
            end
            if (adv) begin
                r_ov <= r_mv;
            end
        end
        if (i_load) begin
            r_mid <= i_mid;
        end
        if (adv && r_mv) begin
            r_kind <= r_mid.kind;
            if (r_mid.kind == KIND_TX) begin
                r_byte   <= b;
                r_status <= ST_READY;
                r_chk    <= r_mid.first ? b : (r_chk ^ b);
            end else begin
                r_byte   <= 8'h00;
                r_status <= r_mid.status;
            end
        end
    end

    assign o_valid   = r_ov;
    assign o_kind    = r_kind;
    assign o_tx_byte = r_byte;
    assign o_status  = r_status;

endmodule

FILE: hdl/uart_bootloader_flash_programmer.sv
`timescale 1ns / 1ps
// Top level of the UART bootloader flash programmer.
// Depends on ubfp_pkg and ubfp_tx.

// Host side of a serial bootloader write-memory session. Op 0 starts a
// session: the block sends the sync byte, the extended global erase, and then
// takes image bytes into a 256-byte block buffer. Each full block, or the block
// that ends with last_byte, is written with the write command, the big-endian
// address with its XOR, and the length, data padded with 0xFF to a multiple of
// four and the XOR checksum. While a frame has bytes left, each tick transfer
// releases one byte; after each frame the block waits for ACK, and a NACK, bad
// byte or timeout resends the frame up to the configured retry count. Status
// transfers report ready for the next block, image done, failure, or an image
// byte that arrived out of place. An input transfer can be taken each cycle
// unless the input stalls. A result passes through the middle stage, which holds
// the synchronous read of the block buffer, and then the output register. The
// input stalls only while both the middle stage and the output register hold
// results that the receiver has not yet taken. Configuration writes take
// effect on the next cycle and must only be made while the block is idle.
module uart_bootloader_flash_programmer
    import ubfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_COLLECT, PH_SYNC, PH_ERASE_CMD, PH_ERASE_ARG,
        PH_WRITE_CMD, PH_ADDR, PH_DATA
    } t_phase;

    // Configuration registers.
    logic [31:0] r_cfg_tmo;
    logic [3:0]  r_cfg_retries;
    logic [31:0] r_cfg_base;

    // Session state.
    t_phase           r_phase,  n_phase;
    logic [CNT_W-1:0] r_fill,   n_fill;
    logic [CNT_W-1:0] r_pad,    n_pad;
    logic [CNT_W-1:0] r_idx,    n_idx;
    logic [31:0]      r_addr,   n_addr;
    logic [3:0]       r_retry,  n_retry;
    logic [31:0]      r_tmo,    n_tmo;
    logic             r_final,  n_final;

    logic             accept;
    logic             can_load;
    logic             emit;
    t_mid             mid;
    logic             we;
    logic [BUF_AW-1:0] waddr;
    logic             re;
    logic [BUF_AW-1:0] raddr;
    logic [CNT_W-1:0] flen;
    logic [CNT_W-1:0] fill_inc;
    logic [CNT_W-1:0] data_pos;
    logic             framing;
    logic             do_ack;
    logic             do_fail;
    t_op              op;

    assign op      = t_op'(i_op);
    assign o_ready = can_load;
    assign accept  = i_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_tmo     <= TIMEOUT_RESET;
            r_cfg_retries <= RETRIES_RESET;
            r_cfg_base    <= BASE_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_TIMEOUT: r_cfg_tmo     <= i_cfg_data;
                CFG_RETRIES: r_cfg_retries <= i_cfg_data[3:0];
                CFG_BASE:    r_cfg_base    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_SYNC:      flen = CNT_W'(1);
            PH_ERASE_CMD: flen = CNT_W'(2);
            PH_ERASE_ARG: flen = CNT_W'(3);
            PH_WRITE_CMD: flen = CNT_W'(2);
            PH_ADDR:      flen = CNT_W'(5);
            PH_DATA:      flen = r_pad + CNT_W'(2);
            default:      flen = '0;
        endcase
    end

    assign framing  = (r_phase != PH_IDLE) && (r_phase != PH_COLLECT);
    assign fill_inc = r_fill + CNT_W'(1);
    assign data_pos = r_idx - CNT_W'(1);

    always_comb begin
        n_phase = r_phase;
        n_fill  = r_fill;
        n_pad   = r_pad;
        n_idx   = r_idx;
        n_addr  = r_addr;
        n_retry = r_retry;
        n_tmo   = r_tmo;
        n_final = r_final;
        emit    = 1'b0;
        mid     = '{kind: KIND_TX, status: ST_READY, sel: SEL_CONST,
                    cbyte: 8'h00, first: 1'b0};
        we      = 1'b0;
        waddr   = r_fill[BUF_AW-1:0];
        re      = 1'b0;
        raddr   = data_pos[BUF_AW-1:0];
        do_ack  = 1'b0;
        do_fail = 1'b0;

        unique case (op)
            OP_START: begin
                n_addr  = r_cfg_base;
                n_fill  = '0;
                n_pad   = '0;
                n_final = 1'b0;
                n_phase = PH_SYNC;
                n_idx   = '0;
                n_retry = '0;
                n_tmo   = '0;
            end
            OP_IMAGE: begin
                if (r_phase != PH_COLLECT) begin
                    emit       = 1'b1;
                    mid.kind   = KIND_STATUS;
                    mid.status = ST_REJECTED;
                end else begin
                    we     = 1'b1;
                    n_fill = fill_inc;
                    if (i_last_byte) begin
                        n_final = 1'b1;
                    end
                    if (i_last_byte || fill_inc >= CNT_W'(BLOCK_BYTES)) begin
                        n_pad   = (fill_inc + CNT_W'(3)) & ~CNT_W'(3);
                        n_phase = PH_WRITE_CMD;
                        n_idx   = '0;
                        n_retry = '0;
                        n_tmo   = '0;
                    end
                end
            end
            OP_RSP: begin
                if (framing && r_idx >= flen) begin
                    if (i_data_byte == RSP_ACK) begin
                        do_ack = 1'b1;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
            end
            default: begin
                if (framing) begin
                    if (r_idx < flen) begin
                        emit      = 1'b1;
                        mid.first = (r_idx == '0);
                        unique case (r_phase)
                            PH_SYNC:      mid.cbyte = BYTE_SYNC;
                            PH_ERASE_CMD: mid.cbyte = (r_idx != '0) ? BYTE_ERASE_N
                                                                    : BYTE_ERASE;
                            PH_ERASE_ARG: begin
                                if (r_idx < CNT_W'(2)) begin
                                    mid.cbyte = BYTE_FILL;
                                end else begin
                                    mid.sel = SEL_CHK;
                                end
                            end
                            PH_WRITE_CMD: mid.cbyte = (r_idx != '0) ? BYTE_WRITE_N
                                                                    : BYTE_WRITE;
                            PH_ADDR: begin
                                case (r_idx[2:0])
                                    3'd0:    mid.cbyte = r_addr[31:24];
                                    3'd1:    mid.cbyte = r_addr[23:16];
                                    3'd2:    mid.cbyte = r_addr[15:8];
                                    3'd3:    mid.cbyte = r_addr[7:0];
                                    default: mid.sel   = SEL_CHK;
                                endcase
                            end
                            default: begin
                                if (r_idx == '0) begin
                                    mid.cbyte = data_pos[7:0];
                                    mid.cbyte = 8'(r_pad - CNT_W'(1));
                                end else if (r_idx <= r_pad) begin
                                    if (data_pos < r_fill) begin
                                        mid.sel = SEL_MEM;
                                        re      = 1'b1;
                                    end else begin
                                        mid.cbyte = BYTE_FILL;
                                    end
                                end else begin
                                    mid.sel = SEL_CHK;
                                end
                            end
                        endcase
                        n_idx = r_idx + CNT_W'(1);
                        if (n_idx >= flen) begin
                            n_tmo = r_cfg_tmo;
                        end
                    end else if (r_tmo <= 32'd1) begin
                        n_tmo   = '0;
                        do_fail = 1'b1;
                    end else begin
                        n_tmo = r_tmo - 32'd1;
                    end
                end
            end
        endcase

        // A failed attempt resends the frame or gives up.
        if (do_fail) begin
            n_idx = '0;
            n_tmo = '0;
            if (r_retry < r_cfg_retries) begin
                n_retry = r_retry + 4'd1;
            end else begin
                n_phase    = PH_IDLE;
                emit       = 1'b1;
                mid.kind   = KIND_STATUS;
                mid.status = ST_FAILED;
            end
        end

        // An acknowledged frame moves on to the next frame, to collecting the next block, or to idle after the last.
        if (do_ack) begin
            n_idx   = '0;
            n_retry = '0;
            n_tmo   = '0;
            unique case (r_phase)
                PH_SYNC:      n_phase = PH_ERASE_CMD;
                PH_ERASE_CMD: n_phase = PH_ERASE_ARG;
                PH_ERASE_ARG: begin
                    n_phase    = PH_COLLECT;
                    n_fill     = '0;
                    emit       = 1'b1;
                    mid.kind   = KIND_STATUS;
                    mid.status = ST_READY;
                end
                PH_WRITE_CMD: n_phase = PH_ADDR;
                PH_ADDR:      n_phase = PH_DATA;
                default: begin
                    n_addr     = r_addr + 32'(r_fill);
                    n_fill     = '0;
                    emit       = 1'b1;
                    mid.kind   = KIND_STATUS;
                    if (r_final) begin
                        n_phase    = PH_IDLE;
                        mid.status = ST_DONE;
                    end else begin
                        n_phase    = PH_COLLECT;
                        mid.status = ST_READY;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fill  <= '0;
            r_pad   <= '0;
            r_idx   <= '0;
            r_addr  <= '0;
            r_retry <= '0;
            r_tmo   <= '0;
            r_final <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_fill  <= n_fill;
            r_pad   <= n_pad;
            r_idx   <= n_idx;
            r_addr  <= n_addr;
            r_retry <= n_retry;
            r_tmo   <= n_tmo;
            r_final <= n_final;
        end
    end

    ubfp_tx u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && emit),
        .i_mid      (mid),
        .i_we       (accept && we),
        .i_waddr    (waddr),
        .i_wdata    (i_data_byte),
        .i_re       (accept && re),
        .i_raddr    (raddr),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_kind     (o_kind),
        .o_tx_byte  (o_tx_byte),
        .o_status   (o_status)
    );

endmodule
